FILE: design/bdc_pkg.sv
`default_nettype none
package bdc_pkg;

  localparam int VALUE_W        = 32;
  localparam int NUM_DIGITS     = 10;
  localparam int DIGIT_W        = 4;
  localparam int IDX_W          = 4;
  localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int BITS_PER_CYCLE = 4;
  localparam int CONV_CYCLES    = VALUE_W / BITS_PER_CYCLE;
  localparam int CNT_W          = $clog2(CONV_CYCLES);
  localparam int CHAR_W         = 8;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_CR   = 8'd13;
  localparam logic [CHAR_W-1:0]  CHAR_LF   = 8'd10;
  localparam logic [DIGIT_W-1:0] DD_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_ADJUST = 4'd3;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    bcd_t             digits;
    logic [IDX_W-1:0] top_idx;
  } entry_t;

  // one double-dabble step: add-3 adjust, then shift in one binary bit
  function automatic bcd_t dd_step(input bcd_t b, input logic bit_in);
    bcd_t             a;
    logic [BCD_W-1:0] flat;
    a = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (a[i] >= DD_LIMIT) begin
        a[i] = a[i] + DD_ADJUST;
      end
    end
    flat = a;
    return bcd_t'({flat[BCD_W-2:0], bit_in});
  endfunction

  // index of the most significant nonzero digit, zero for a zero value
  function automatic logic [IDX_W-1:0] top_index(input bcd_t b);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (b[i] != '0) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: design/bdc_front.sv
`default_nettype none
module bdc_front
  import bdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output entry_t                  push_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t       st_r, st_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt, bin_step;
  bcd_t               bcd_r, bcd_nxt, bcd_step;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               accept;

  always_comb begin
    bcd_step = bcd_r;
    bin_step = bin_r;
    for (int s = 0; s < BITS_PER_CYCLE; s++) begin
      bcd_step = dd_step(bcd_step, bin_step[VALUE_W-1]);
      bin_step = bin_step << 1;
    end
  end

  assign in_stall   = !((st_r == F_IDLE) || ((st_r == F_PUSH) && push_ready));
  assign accept     = in_valid && !in_stall;
  assign push_valid = (st_r == F_PUSH);
  assign push_data  = '{digits: bcd_r, top_idx: top_index(bcd_r)};

  always_comb begin
    st_nxt  = st_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      F_IDLE: begin
        if (accept) st_nxt = F_CONV;
      end
      F_CONV: begin
        bin_nxt = bin_step;
        bcd_nxt = bcd_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CONV_CYCLES - 1)) st_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) st_nxt = accept ? F_CONV : F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
    if (accept) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (st_r == F_CONV) && (cnt_r == '0))
    else $error("front: accepted request did not start conversion");

endmodule
`default_nettype wire

FILE: design/bdc_fifo.sv
`default_nettype none
module bdc_fifo
  import bdc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_data,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output entry_t      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fifo: occupancy above depth");

endmodule
`default_nettype wire

FILE: design/bdc_back.sv
`default_nettype none
module bdc_back
  import bdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  wire entry_t      pop_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic             out_last
);

  typedef enum logic [2:0] {
    PH_DIG = 3'b001,
    PH_CR  = 3'b010,
    PH_LF  = 3'b100
  } phase_t;

  phase_t            ph_r, ph_nxt;
  logic              busy_r, busy_nxt;
  bcd_t              digits_r, digits_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              advance, load;

  assign advance   = !out_valid_r || !out_stall;
  assign pop_ready = advance && (!busy_r || (ph_r == PH_LF));
  assign load      = pop_ready && pop_valid;

  always_comb begin
    ph_nxt        = ph_r;
    busy_nxt      = busy_r;
    digits_nxt    = digits_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        unique case (ph_r)
          PH_DIG: begin
            out_char_nxt = CHAR_ZERO + CHAR_W'(digits_r[idx_r]);
            out_last_nxt = 1'b0;
            if (idx_r == '0) ph_nxt = PH_CR;
            else idx_nxt = idx_r - 1'b1;
          end
          PH_CR: begin
            out_char_nxt = CHAR_CR;
            out_last_nxt = 1'b0;
            ph_nxt       = PH_LF;
          end
          PH_LF: begin
            out_char_nxt = CHAR_LF;
            out_last_nxt = 1'b1;
            busy_nxt     = 1'b0;
          end
          default: begin
            ph_nxt   = PH_DIG;
            busy_nxt = 1'b0;
          end
        endcase
      end
    end
    if (load) begin
      busy_nxt   = 1'b1;
      digits_nxt = pop_data.digits;
      idx_nxt    = pop_data.top_idx;
      ph_nxt     = PH_DIG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_DIG;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_character == CHAR_LF))
    else $error("back: last flag on a character other than line feed");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_character >= CHAR_ZERO && out_character <= CHAR_ZERO + 8'd9)
                   || out_character == CHAR_CR || out_character == CHAR_LF))
    else $error("back: character outside digits, CR and LF");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || ph_r == PH_LF))
    else $error("back: new value loaded in the middle of a line");

endmodule
`default_nettype wire

FILE: design/binary_to_decimal_ascii.sv
// Flow: an accepted value is converted by double dabble at 4 bits per cycle,
// pushed into the queue, loaded by the back end and registered at the output.
// Throughput: front end takes a new value only once the last is pushed; back end
// sends one character per cycle unless stalled; the slower of the two sets the rate.
// Reset: synchronous active-low rst_n clears control state; queue and pipe empty.
`default_nettype none
module binary_to_decimal_ascii
  import bdc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CHAR_W-1:0]       out_character,
  output logic                    out_last
);

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  bdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bdc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bdc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

FILE: dv/tb_binary_to_decimal_ascii.sv
module tb_binary_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;
  import bdc_pkg::*;

  localparam int DEC_RADIX    = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  char_t char_q[$];
  int    errors = 0;
  int    tx_idle_pct = 24;
  int    rx_idle_pct = 24;
  int    hold_seq = 0;
  int    hold_seen = 0;
  int    hold_left = 0;

  binary_to_decimal_ascii uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #1 clk = ~clk;

  initial begin
    #400us;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag(input string msg);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("%t mismatch: %s", $realtime, msg);
    end
  endtask

  // expected line for one value: digits msb first, no leading zeros, then CR LF
  function automatic void render_decimal(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] dig[NUM_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    char_t              c;
    rest = v;
    n = 0;
    do begin
      dig[n] = DIGIT_W'(rest % DEC_RADIX);
      rest = rest / DEC_RADIX;
      n++;
    end while (rest != 0);
    for (int d = n - 1; d >= 0; d--) begin
      c.code = CHAR_ZERO + CHAR_W'(dig[d]);
      c.last = 1'b0;
      char_q.push_back(c);
    end
    c.code = CHAR_CR;
    c.last = 1'b0;
    char_q.push_back(c);
    c.code = CHAR_LF;
    c.last = 1'b1;
    char_q.push_back(c);
  endfunction

  // result side: stall generation and checking
  always @(posedge clk) begin
    char_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (char_q.size() == 0) begin
        flag($sformatf("unexpected char %0d last %0b", out_character, out_last));
      end else begin
        e = char_q.pop_front();
        if (out_character !== e.code) begin
          flag($sformatf("char exp %0d got %0d", e.code, out_character));
        end
        if (out_last !== e.last) begin
          flag($sformatf("last exp %0b got %0b (char %0d)", e.last, out_last, e.code));
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= $urandom();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    render_decimal(v);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] value_of_digits(input int n);
    longint lo;
    longint hi;
    lo = (n == 1) ? 0 : 1;
    for (int i = 1; i < n; i++) lo = lo * DEC_RADIX;
    hi = (n == 1) ? DEC_RADIX - 1 : lo * DEC_RADIX - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(int'(hi), int'(lo));
  endfunction

  task automatic test_directed();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000,
             32'd99999, 32'd100000, 32'd999999999, 32'd1000000000,
             32'd2147483647, 32'd2147483648, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
             32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000, 32'd1234567890};
    foreach (vals[i]) send_value(vals[i]);
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 20; i++) send_value(value_of_digits($urandom_range(10, 1)));
    tx_idle_pct = 24;
    drain_results();
  endtask

  task automatic test_random_sizes();
    for (int i = 0; i < 50; i++) send_value(value_of_digits($urandom_range(10, 1)));
    drain_results();
  endtask

  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 30; i++) send_value(value_of_digits($urandom_range(10, 1)));
    tx_idle_pct = 24;
    rx_idle_pct = 24;
    drain_results();
  endtask

  task automatic test_random_full();
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(3) == 0) begin
        send_value(value_of_digits($urandom_range(3, 1)));
      end else begin
        send_value($urandom());
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_sizes();
    test_no_idle();
    test_random_full();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bdc_pkg.sv
design/bdc_front.sv
design/bdc_fifo.sv
design/bdc_back.sv
design/binary_to_decimal_ascii.sv
dv/tb_binary_to_decimal_ascii.sv
